// ----- rtl/tsip_pkg.sv -----
// Shared constants and character decode for the text-to-integer parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tsip_pkg;

  localparam int unsigned VALUE_BITS_DEF  = 32;
  localparam int unsigned OFFSET_BITS_DEF = 16;
  localparam int unsigned BASE_W          = 6;
  localparam int unsigned DIGIT_W         = 6;
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned PADDR_W         = 3;

  // Register index, taken from paddr[2]
  localparam logic REG_NUMBER_BASE = 1'b0;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7a;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;

  localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
  localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
  localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

  // Never below any 6-bit base, so it always fails the digit check
  localparam logic [DIGIT_W-1:0] NOT_DIGIT = 6'd63;

  function automatic logic [DIGIT_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] t;
    t = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      t = c - CH_ZERO;
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      t = c - (CH_UP_A - 8'd10);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      t = c - (CH_LO_A - 8'd10);
    end else begin
      t = {2'b00, NOT_DIGIT};
    end
    return t[DIGIT_W-1:0];
  endfunction

endpackage

// ----- rtl/tsip_accum.sv -----
// Saturating multiply-accumulate step: acc * base + digit against the signed limit.
// Depends on tsip_pkg.
`timescale 1ns / 1ps

module tsip_accum
  import tsip_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic [VALUE_BITS-1:0] acc_i,
  input  logic [BASE_W-1:0]     base_i,
  input  logic [DIGIT_W-1:0]    digit_i,
  input  logic                  neg_i,
  input  logic                  ovf_i,
  output logic [VALUE_BITS-1:0] acc_o,
  output logic                  ovf_o
);

  localparam int unsigned PW = VALUE_BITS + BASE_W + 1;

  logic [PW-1:0] prod;
  logic [PW-1:0] limit;
  logic          over;

  assign prod  = PW'(acc_i) * PW'(base_i) + PW'(digit_i);
  assign limit = (PW'(1) << (VALUE_BITS - 1)) - PW'(!neg_i);
  assign over  = prod > limit;

  assign ovf_o = ovf_i || over;
  assign acc_o = (ovf_i || over) ? acc_i : prod[VALUE_BITS-1:0];

endmodule

// ----- rtl/tsip_parser.sv -----
// Parse state machine: spaces, sign, base prefix, digits and result forming.
// Depends on tsip_pkg and tsip_accum.
`timescale 1ns / 1ps

module tsip_parser
  import tsip_pkg::*;
#(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  logic [CHAR_W-1:0]      char_i,
  input  logic                   start_i,
  input  logic [BASE_W-1:0]      base_i,
  output logic                   res_valid_o,
  output logic [VALUE_BITS-1:0]  value_o,
  output logic                   ovf_o,
  output logic                   any_o,
  output logic [OFFSET_BITS-1:0] offset_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS,
    PH_DONE
  } phase_e;

  phase_e                 phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic [VALUE_BITS-1:0]  acc_q, acc_d;
  logic                   ovf_q, ovf_d;
  logic                   any_q, any_d;
  logic [BASE_W-1:0]      eb_q, eb_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;

  phase_e                 ph_c;
  logic                   neg_c, ovf_c, any_c, run_digit;
  logic [VALUE_BITS-1:0]  acc_c;
  logic [BASE_W-1:0]      eb_c;
  logic [OFFSET_BITS-1:0] pos_c;
  logic [BASE_W-1:0]      eb_run;
  logic [DIGIT_W-1:0]     dig;
  logic                   prefix_ok;
  logic [VALUE_BITS-1:0]  acc_nx;
  logic                   ovf_nx;

  assign dig       = digit_value(char_i);
  assign prefix_ok = (base_i == BASE_AUTO) || (base_i == BASE_HEX);

  always_comb begin
    ph_c  = start_i ? PH_SPACE : phase_q;
    neg_c = start_i ? 1'b0 : neg_q;
    acc_c = start_i ? '0 : acc_q;
    ovf_c = start_i ? 1'b0 : ovf_q;
    any_c = start_i ? 1'b0 : any_q;
    eb_c  = start_i ? '0 : eb_q;
    pos_c = start_i ? '0 : pos_q;
  end

  assign eb_run = (ph_c == PH_DIGITS) ? eb_c :
                  (ph_c == PH_ZERO)   ? ((base_i == BASE_AUTO) ? BASE_OCT : BASE_HEX) :
                                        ((base_i == BASE_AUTO) ? BASE_DEC : base_i);

  tsip_accum #(
    .VALUE_BITS(VALUE_BITS)
  ) u_accum (
    .acc_i  (acc_c),
    .base_i (eb_run),
    .digit_i(dig),
    .neg_i  (neg_c),
    .ovf_i  (ovf_c),
    .acc_o  (acc_nx),
    .ovf_o  (ovf_nx)
  );

  always_comb begin
    phase_d   = ph_c;
    neg_d     = neg_c;
    acc_d     = acc_c;
    ovf_d     = ovf_c;
    any_d     = any_c;
    eb_d      = eb_c;
    pos_d     = pos_c;
    run_digit = 1'b0;

    unique case (ph_c)
      PH_SPACE, PH_SIGNED: begin
        if (ph_c == PH_SPACE && char_i == CH_SPACE) begin
          phase_d = PH_SPACE;
        end else if (ph_c == PH_SPACE && char_i == CH_MINUS) begin
          neg_d   = 1'b1;
          phase_d = PH_SIGNED;
        end else if (ph_c == PH_SPACE && char_i == CH_PLUS) begin
          phase_d = PH_SIGNED;
        end else if (char_i == CH_ZERO && prefix_ok) begin
          phase_d = PH_ZERO;
        end else begin
          eb_d      = (base_i == BASE_AUTO) ? BASE_DEC : base_i;
          run_digit = 1'b1;
        end
      end
      PH_ZERO: begin
        if (char_i == CH_LO_X || char_i == CH_UP_X) begin
          eb_d    = BASE_HEX;
          phase_d = PH_DIGITS;
        end else begin
          // leading zero counts as a digit
          eb_d      = (base_i == BASE_AUTO) ? BASE_OCT : BASE_HEX;
          any_d     = 1'b1;
          run_digit = 1'b1;
        end
      end
      PH_DIGITS: begin
        run_digit = 1'b1;
      end
      PH_IDLE, PH_DONE: begin
        phase_d = ph_c;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    res_valid_o = 1'b0;
    if (run_digit) begin
      phase_d = PH_DIGITS;
      if (dig < eb_d) begin
        acc_d = acc_nx;
        ovf_d = ovf_nx;
        any_d = 1'b1;
      end else begin
        res_valid_o = 1'b1;
        phase_d     = PH_DONE;
      end
    end

    if (ph_c != PH_IDLE && ph_c != PH_DONE && pos_c != '1) begin
      pos_d = pos_c + 1'b1;
    end

    if (ovf_d) begin
      value_o = neg_d ? {1'b1, {(VALUE_BITS-1){1'b0}}} : {1'b0, {(VALUE_BITS-1){1'b1}}};
    end else begin
      value_o = neg_d ? (~acc_d + 1'b1) : acc_d;
    end
    ovf_o    = ovf_d;
    any_o    = any_d;
    offset_o = any_d ? pos_c : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      ovf_q   <= 1'b0;
      any_q   <= 1'b0;
      eb_q    <= '0;
      pos_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      acc_q   <= acc_d;
      ovf_q   <= ovf_d;
      any_q   <= any_d;
      eb_q    <= eb_d;
      pos_q   <= pos_d;
    end
  end

endmodule

// ----- rtl/text_to_signed_integer_parser.sv -----
// Input and result are both registered. Throughput: one character
// per cycle unless the result stalls; set by the single accumulate step per character.
// A stalled result holds the parse step; the input register still takes one character.
// Reset (rst_ni low, asynchronous) clears the parse state, the base register to 0
// and both valid flags; payload registers are not reset.
// Depends on tsip_pkg and tsip_parser.
`timescale 1ns / 1ps

module text_to_signed_integer_parser
  import tsip_pkg::*;
#(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF,
  localparam int unsigned TDATA_W    = ((VALUE_BITS + OFFSET_BITS + 7) / 8) * 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // character stream in
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // [7:0] char_code
  input  logic [0:0]         s_axis_tuser,   // [0] string_start
  // result stream out
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [TDATA_W-1:0] m_axis_tdata,   // parsed_value, end_offset, zero pad
  output logic [1:0]         m_axis_tuser    // [0] overflowed, [1] digits_found
);

  logic [BASE_W-1:0]      base_q;
  logic                   in_valid_q;
  logic [CHAR_W-1:0]      in_char_q;
  logic                   in_start_q;
  logic                   out_valid_q, out_valid_d;
  logic [VALUE_BITS-1:0]  out_value_q;
  logic [OFFSET_BITS-1:0] out_offset_q;
  logic                   out_ovf_q, out_any_q;
  logic                   advance;
  logic                   res_valid;
  logic [VALUE_BITS-1:0]  res_value;
  logic                   res_ovf, res_any;
  logic [OFFSET_BITS-1:0] res_offset;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NUMBER_BASE) ? {{(32-BASE_W){1'b0}}, base_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_AUTO;
    end else if (psel && penable && pwrite && paddr[2] == REG_NUMBER_BASE) begin
      base_q <= pwdata[BASE_W-1:0];
    end
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser[0];
    end
  end

  tsip_parser #(
    .VALUE_BITS (VALUE_BITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .char_i     (in_char_q),
    .start_i    (in_start_q),
    .base_i     (base_q),
    .res_valid_o(res_valid),
    .value_o    (res_value),
    .ovf_o      (res_ovf),
    .any_o      (res_any),
    .offset_o   (res_offset)
  );

  assign out_valid_d = advance ? res_valid : (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_value_q  <= res_value;
      out_offset_q <= res_offset;
      out_ovf_q    <= res_ovf;
      out_any_q    <= res_any;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = TDATA_W'({out_offset_q, out_value_q});
  assign m_axis_tuser  = {out_any_q, out_ovf_q};

endmodule

// ----- rtl/tsip_checker.sv -----
// Port-level checks on the result stream of the parser.
// Depends on tsip_pkg; bound to text_to_signed_integer_parser.
`timescale 1ns / 1ps

module tsip_checker
  import tsip_pkg::*;
#(
  parameter int unsigned VALUE_BITS  = VALUE_BITS_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF,
  localparam int unsigned TDATA_W    = ((VALUE_BITS + OFFSET_BITS + 7) / 8) * 8
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               m_axis_tvalid,
  input logic               m_axis_tready,
  input logic [TDATA_W-1:0] m_axis_tdata,
  input logic [1:0]         m_axis_tuser
);

  logic [VALUE_BITS-1:0] val;
  logic [OFFSET_BITS-1:0] off;

  assign val = m_axis_tdata[VALUE_BITS-1:0];
  assign off = m_axis_tdata[VALUE_BITS+OFFSET_BITS-1:VALUE_BITS];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_no_digit_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[1] |-> val == '0 && off == '0)
    else $error("result without digits carries nonzero value or offset");

  a_ovf_has_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[1])
    else $error("overflow flagged without digits");

  a_ovf_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |->
      val == {1'b1, {(VALUE_BITS-1){1'b0}}} || val == {1'b0, {(VALUE_BITS-1){1'b1}}})
    else $error("overflowed result is not saturated");

endmodule

bind text_to_signed_integer_parser tsip_checker #(
  .VALUE_BITS (VALUE_BITS),
  .OFFSET_BITS(OFFSET_BITS)
) u_tsip_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);

// ----- tb/text_to_signed_integer_parser_tb.sv -----
// Self-checking testbench for text_to_signed_integer_parser: streams characters, predicts
// each parsed number in a local model and compares every result transaction field by field.
// Depends on tsip_pkg and the parser RTL.
`timescale 1ns / 1ps

module text_to_signed_integer_parser_tb;
  import tsip_pkg::*;

  localparam int TDATA_W      = 48;
  localparam int LATENCY_WAIT = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int LONG_RUN     = 100;
  localparam int PHASE_ITEMS  = 140;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam logic [PADDR_W-1:0] BASE_ADDR = {REG_NUMBER_BASE, 2'b00};

  typedef enum logic [2:0] {
    PH_IDLE, PH_SPACE, PH_SIGNED, PH_ZERO, PH_DIGITS, PH_DONE
  } phase_e;

  typedef struct packed {
    logic signed [31:0] value;
    logic               overflowed;
    logic               digits_found;
    logic [15:0]        end_offset;
  } number_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [7:0]         s_axis_tdata = '0;   // [7:0] char_code
  logic [0:0]         s_axis_tuser = '0;   // [0] string_start
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata;        // [31:0] parsed_value, [47:32] end_offset
  logic [1:0]         m_axis_tuser;        // [0] overflowed, [1] digits_found

  text_to_signed_integer_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // parser model state
  logic [5:0]      base_reg = BASE_AUTO;
  phase_e          pstate = PH_IDLE;
  logic            sign_neg = 1'b0;
  longint unsigned accum = 0;
  logic            sat_seen = 1'b0;
  logic            digit_seen = 1'b0;
  logic [5:0]      radix = '0;
  logic [15:0]     offset_cnt = '0;
  number_t         numbers_due[$];

  int          fail_count = 0;
  int          cycle_count = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  bit          stall_on = 1'b1;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          run_left = 0;
  bit          run_ready = 1'b0;
  logic [7:0]  text_q[$];
  bit          text_first;
  number_t     want;
  number_t     got;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned char_digit(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
    if (c >= CH_UP_A && c <= CH_UP_Z) return c - CH_UP_A + 10;
    if (c >= CH_LO_A && c <= CH_LO_Z) return c - CH_LO_A + 10;
    return 255;
  endfunction

  function automatic logic [7:0] digit_char(int d, bit upper);
    if (d < 10) return CH_ZERO + 8'(d);
    return (upper ? CH_UP_A : CH_LO_A) + 8'(d - 10);
  endfunction

  function automatic void take_digit(int unsigned d);
    longint unsigned lim;
    longint unsigned cut;
    longint unsigned rem;
    lim = 64'h8000_0000;
    if (!sign_neg) lim = lim - 1;
    cut = lim / radix;
    rem = lim % radix;
    if (sat_seen || accum > cut || (accum == cut && d > rem)) begin
      sat_seen = 1'b1;
    end else begin
      accum = accum * radix + d;
    end
    digit_seen = 1'b1;
  endfunction

  function automatic void digit_or_end(logic [7:0] c);
    int unsigned d;
    number_t n;
    d = char_digit(c);
    if (d != 255 && d < radix) begin
      take_digit(d);
      return;
    end
    if (sat_seen) begin
      n.value = sign_neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      n.value = sign_neg ? 32'(64'd0 - accum) : 32'(accum);
    end
    n.overflowed   = sat_seen;
    n.digits_found = digit_seen;
    n.end_offset   = digit_seen ? offset_cnt : '0;
    numbers_due.push_back(n);
    pstate = PH_DONE;
  endfunction

  function automatic void first_after_sign(logic [7:0] c);
    if (c == CH_ZERO && (base_reg == BASE_AUTO || base_reg == BASE_HEX)) begin
      pstate = PH_ZERO;
    end else begin
      radix  = (base_reg == BASE_AUTO) ? BASE_DEC : base_reg;
      pstate = PH_DIGITS;
      digit_or_end(c);
    end
  endfunction

  function automatic bit parse_char(logic [7:0] c, logic first);
    if (first) begin
      pstate     = PH_SPACE;
      sign_neg   = 1'b0;
      accum      = 0;
      sat_seen   = 1'b0;
      digit_seen = 1'b0;
      radix      = '0;
      offset_cnt = '0;
    end
    if (pstate == PH_IDLE || pstate == PH_DONE) return 1'b0;
    case (pstate)
      PH_SPACE: begin
        if (c == CH_MINUS) begin
          sign_neg = 1'b1;
          pstate   = PH_SIGNED;
        end else if (c == CH_PLUS) begin
          pstate = PH_SIGNED;
        end else if (c != CH_SPACE) begin
          first_after_sign(c);
        end
      end
      PH_SIGNED: first_after_sign(c);
      PH_ZERO: begin
        if (c == CH_LO_X || c == CH_UP_X) begin
          radix  = BASE_HEX;
          pstate = PH_DIGITS;
        end else begin
          radix = (base_reg == BASE_AUTO) ? BASE_OCT : BASE_HEX;
          take_digit(0);
          pstate = PH_DIGITS;
          digit_or_end(c);
        end
      end
      default: digit_or_end(c);
    endcase
    if (offset_cnt != '1) offset_cnt++;
    return 1'b1;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic first, output bit taken);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = gaps_on ? $urandom_range(1, 8) : 0;
    end
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    taken = parse_char(c, first);
    burst_left--;
  endtask

  task automatic send_text(input string s, input logic start);
    bit taken;
    for (int i = 0; i < s.len(); i++) send_char(s[i], start && (i == 0), taken);
  endtask

  task automatic wait_results_done();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (numbers_due.size() != 0) @(negedge clk_i);
    repeat (LATENCY_WAIT) @(negedge clk_i);
  endtask

  task automatic set_base(input logic [5:0] v);
    wait_results_done();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BASE_ADDR;
    pwdata  <= {26'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    base_reg = v;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    psel    <= 1'b1;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {26'd0, base_reg}) begin
      $error("number_base: expected %0d, actual %0d", base_reg, prdata);
      fail_count++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic build_string(input logic [5:0] base);
    int  kind;
    int  eb;
    int  lim;
    int  ndig;
    bit  broken;
    text_q.delete();
    text_first = 1'b1;
    kind = $urandom_range(0, 19);
    if (kind == 0) begin
      text_first = 1'b0;
      repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    broken = (kind == 1);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) text_q.push_back(CH_SPACE);
    case ($urandom_range(0, 2))
      1: text_q.push_back(CH_MINUS);
      2: text_q.push_back(CH_PLUS);
      default: ;
    endcase
    if ($urandom_range(0, 15) == 0) text_q.push_back(CH_SPACE);
    eb = (base == BASE_AUTO) ? 10 : base;
    if ((base == BASE_AUTO || base == BASE_HEX) && $urandom_range(0, 2) == 0) begin
      text_q.push_back(CH_ZERO);
      text_q.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
      eb = 16;
    end else if (base == BASE_AUTO && $urandom_range(0, 3) == 0) begin
      text_q.push_back(CH_ZERO);
      eb = 8;
    end
    lim = (eb > 36) ? 36 : eb;
    case ($urandom_range(0, 9))
      0: ndig = 0;
      1: ndig = $urandom_range(9, 40);
      default: ndig = $urandom_range(1, 8);
    endcase
    repeat (ndig)
      text_q.push_back(digit_char($urandom_range(0, lim - 1), 1'($urandom_range(0, 1))));
    if (!broken) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic test_directed_auto();
    bit taken;
    send_char("Z", 1'b0, taken);
    send_text(" -42,", 1'b1);
    send_text("0x1F ", 1'b1);
    send_text("0xg", 1'b1);
    send_text("- 5", 1'b1);
  endtask

  task automatic test_directed_limits();
    bit taken;
    set_base(6'd36);
    send_text("zik0zj", 1'b1);
    send_char(8'hff, 1'b0, taken);
    send_text("-ZZZZZZ", 1'b1);
    send_char(8'h00, 1'b0, taken);
  endtask

  task automatic test_backpressure();
    bit taken;
    set_base(BASE_DEC);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    repeat (40) begin
      send_char(digit_char($urandom_range(0, 9), 1'b0), 1'b1, taken);
      send_char(";", 1'b0, taken);
    end
    wait_results_done();
  endtask

  task automatic test_long_string();
    bit taken;
    set_base(BASE_DEC);
    gaps_on = 1'b0;
    send_char(CH_ZERO, 1'b1, taken);
    repeat (LONG_RUN) send_char(CH_ZERO, 1'b0, taken);
    send_char(CH_SPACE, 1'b0, taken);
  endtask

  task automatic test_random_phase(input logic [5:0] base);
    int sent;
    bit taken;
    set_base(base);
    gaps_on  = ($urandom_range(0, 3) != 0);
    stall_on = ($urandom_range(0, 3) != 0);
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      build_string(base);
      foreach (text_q[i]) begin
        send_char(text_q[i], text_first && (i == 0), taken);
        if (taken) sent++;
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      if (run_left == 0) begin
        run_ready = ~run_ready;
        run_left  = run_ready ? $urandom_range(1, 10) : $urandom_range(1, 12);
      end
      run_left--;
      m_axis_tready <= stall_on ? run_ready : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.value        = m_axis_tdata[31:0];
      got.end_offset   = m_axis_tdata[47:32];
      got.overflowed   = m_axis_tuser[0];
      got.digits_found = m_axis_tuser[1];
      if (numbers_due.size() == 0) begin
        $error("unexpected result transaction: parsed_value %0d", $signed(got.value));
        fail_count++;
      end else begin
        want = numbers_due.pop_front();
        if (got.value !== want.value) begin
          $error("parsed_value: expected %0d, actual %0d", $signed(want.value),
                 $signed(got.value));
          fail_count++;
        end
        if (got.overflowed !== want.overflowed) begin
          $error("overflowed: expected %0d, actual %0d", want.overflowed, got.overflowed);
          fail_count++;
        end
        if (got.digits_found !== want.digits_found) begin
          $error("digits_found: expected %0d, actual %0d", want.digits_found,
                 got.digits_found);
          fail_count++;
        end
        if (got.end_offset !== want.end_offset) begin
          $error("end_offset: expected %0d, actual %0d", want.end_offset, got.end_offset);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("text_to_signed_integer_parser_tb: FAIL");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_auto();
    test_directed_limits();
    test_backpressure();
    test_long_string();
    test_random_phase(BASE_AUTO);
    test_random_phase(BASE_DEC);
    test_random_phase(BASE_HEX);
    test_random_phase(BASE_OCT);
    test_random_phase(6'd2);
    test_random_phase(6'd36);
    test_random_phase(6'd1);
    test_random_phase(6'd63);
    test_random_phase(6'd40);
    test_random_phase(BASE_AUTO);
    wait_results_done();
    if (fail_count == 0) begin
      $display("text_to_signed_integer_parser_tb: PASS");
    end else begin
      $display("text_to_signed_integer_parser_tb: FAIL");
    end
    $finish;
  end

endmodule
